/* rtl/core/smpq_pkg.sv */
// Shared constants and types for the sorted max priority queue.
`default_nettype none

package smpq_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int CNT_W      = $clog2(DEPTH + 1);

    // result word: top_value, top_valid, entry_count, is_empty, is_full, status
    localparam int RES_W = DATA_WIDTH + 1 + CNT_W + 1 + 1 + 2;

    localparam logic [1:0] MODE_ENQ = 2'd0;
    localparam logic [1:0] MODE_DEQ = 2'd1;
    localparam logic [1:0] MODE_CLR = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // broadcast from the top level to every cell
    typedef struct packed {
        logic                  do_enq;
        logic                  do_deq;
        logic [DATA_WIDTH-1:0] value;
    } smpq_ctl_t;

endpackage

`default_nettype wire

/* rtl/core/smpq_cell.sv */
// One storage cell of the sorted chain: keeps, takes the new value or shifts.
`default_nettype none

module smpq_cell (
    input  wire logic                          clk,
    input  wire smpq_pkg::smpq_ctl_t           ctl,
    input  wire logic                          occ,        // cell holds a live entry
    input  wire logic [smpq_pkg::DATA_WIDTH-1:0] prev_entry,
    input  wire logic                          prev_keep,
    input  wire logic [smpq_pkg::DATA_WIDTH-1:0] next_entry,
    output logic      [smpq_pkg::DATA_WIDTH-1:0] entry,
    output logic                               keep,
    output logic      [smpq_pkg::DATA_WIDTH-1:0] entry_next
);
    import smpq_pkg::*;

    logic [DATA_WIDTH-1:0] entry_reg;

    // equal entries stay ahead of the new value
    assign keep  = occ && (entry_reg >= ctl.value);
    assign entry = entry_reg;

    always_comb
    begin
        priority if (ctl.do_enq)
        begin
            if (keep)
                entry_next = entry_reg;
            else if (prev_keep)
                entry_next = ctl.value;
            else
                entry_next = prev_entry;
        end
        else if (ctl.do_deq)
        begin
            entry_next = next_entry;
        end
        else
        begin
            entry_next = entry_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

`default_nettype wire

/* rtl/core/smpq_out_buf.sv */
// Two-entry result buffer between the queue and the master-side stream.
`default_nettype none

module smpq_out_buf (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       push,
    input  wire logic [smpq_pkg::RES_W-1:0] push_data,
    output logic                            has_room,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic      [smpq_pkg::RES_W-1:0] out_data
);
    import smpq_pkg::*;

    logic [1:0]       cnt_reg, cnt_next;
    logic [RES_W-1:0] data0_reg, data0_next;
    logic [RES_W-1:0] data1_reg, data1_next;
    logic             pop;

    assign pop       = (cnt_reg != 2'd0) && out_ready;
    assign has_room  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_data  = data0_reg;

    always_comb
    begin
        cnt_next   = cnt_reg;
        data0_next = data0_reg;
        data1_next = data1_reg;
        unique case ({push, pop})
            2'b10:
            begin
                if (cnt_reg == 2'd0)
                    data0_next = push_data;
                else
                    data1_next = push_data;
                cnt_next = cnt_reg + 2'd1;
            end
            2'b01:
            begin
                data0_next = data1_reg;
                cnt_next   = cnt_reg - 2'd1;
            end
            2'b11:
            begin
                if (cnt_reg == 2'd1)
                begin
                    data0_next = push_data;
                end
                else
                begin
                    data0_next = data1_reg;
                    data1_next = push_data;
                end
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        data0_reg <= data0_next;
        data1_reg <= data1_next;
    end

endmodule

`default_nettype wire

/* rtl/core/sorted_max_priority_queue.sv */
// Top level of the sorted max priority queue: cell chain, count and result path.
`default_nettype none

// Holds up to DEPTH unsigned values in descending order in a row of cells,
// the largest in cell 0. Each transaction on the slave side is one operation
// (enqueue, dequeue, clear) and yields one result on the master side that
// describes the queue after the operation. All cells compare against the
// broadcast value and shift toward or away from the head in the same cycle,
// so the whole row is updated together; a new transaction can be taken in
// every cycle while the two-entry result buffer has room. Enqueue on a full
// queue and dequeue on an empty one leave the queue unchanged and are
// flagged in status. Results are registered in the output buffer.
module sorted_max_priority_queue (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // mode[1:0], value[33:2], zero pad
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [47:0] m_tdata    // top_value[31:0], top_valid[32],
                                        // entry_count[37:33], is_empty[38],
                                        // is_full[39], status[41:40], zero pad
);
    import smpq_pkg::*;

    logic                  accept;
    logic [1:0]            mode;
    logic [DATA_WIDTH-1:0] value;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  enq_ok, deq_ok;
    logic [1:0]            status;
    smpq_ctl_t             ctl;
    logic                  buf_room;
    logic [RES_W-1:0]      res;
    logic [RES_W-1:0]      res_out;
    logic [DATA_WIDTH-1:0] top_value;

    logic [DATA_WIDTH-1:0] entry    [DEPTH];
    logic [DATA_WIDTH-1:0] entry_nx [DEPTH];
    logic                  keep     [DEPTH];
    logic                  occ      [DEPTH];

    assign s_tready = buf_room;
    assign accept   = s_tvalid && s_tready;
    assign mode     = s_tdata[1:0];
    assign value    = s_tdata[2 +: DATA_WIDTH];

    assign enq_ok = accept && (mode == MODE_ENQ) && (count_reg != CNT_W'(DEPTH));
    assign deq_ok = accept && (mode == MODE_DEQ) && (count_reg != '0);

    assign ctl.do_enq = enq_ok;
    assign ctl.do_deq = deq_ok;
    assign ctl.value  = value;

    always_comb
    begin
        status = ST_OK;
        if (mode == MODE_ENQ && count_reg == CNT_W'(DEPTH))
            status = ST_FULL;
        else if (mode == MODE_DEQ && count_reg == '0)
            status = ST_EMPTY;
    end

    always_comb
    begin
        count_next = count_reg;
        priority if (enq_ok)
            count_next = count_reg + CNT_W'(1);
        else if (deq_ok)
            count_next = count_reg - CNT_W'(1);
        else if (accept && mode == MODE_CLR)
            count_next = '0;
        else
            count_next = count_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [DATA_WIDTH-1:0] prev_e;
        logic                  prev_k;
        logic [DATA_WIDTH-1:0] next_e;

        assign occ[i] = CNT_W'(i) < count_reg;

        if (i == 0)
        begin : g_head
            assign prev_e = value;
            assign prev_k = 1'b1;   // head takes the value unless it stays
        end
        else
        begin : g_body
            assign prev_e = entry[i-1];
            assign prev_k = keep[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign next_e = entry[i];
        end
        else
        begin : g_mid
            assign next_e = entry[i+1];
        end

        smpq_cell u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .occ        (occ[i]),
            .prev_entry (prev_e),
            .prev_keep  (prev_k),
            .next_entry (next_e),
            .entry      (entry[i]),
            .keep       (keep[i]),
            .entry_next (entry_nx[i])
        );
    end

    assign top_value = (count_next != '0) ? entry_nx[0] : '0;

    assign res = {status,
                  count_next == CNT_W'(DEPTH),
                  count_next == '0,
                  count_next,
                  count_next != '0,
                  top_value};

    smpq_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (res),
        .has_room  (buf_room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (res_out)
    );

    assign m_tdata = {{(48 - RES_W){1'b0}}, res_out};

endmodule

`default_nettype wire
